@@ rtl/kwl_pkg.sv @@
// kwl_pkg: shared types and constants for the keyword token lexer
// word layouts for the input and result channels, token kind codes, fixed widths
// depends on nothing

package kwl_pkg;

    // fixed field widths
    localparam int unsigned CH_W    = 8;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned START_W = 16;
    localparam int unsigned LEN_W   = 16;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // result queue depth
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // token kinds
    localparam logic [KIND_W-1:0] KIND_LET     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PRINT   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_WORD    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_STAR    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_EQUAL   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd11;
    localparam logic [KIND_W-1:0] KIND_END     = 4'd12;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd13;

    // punctuation bytes
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            end_of_source;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start_res;
        logic [LEN_W-1:0]   length;
        logic [CH_W-1:0]    bad_char;
        logic               last;
    } t_out_word;

endpackage

@@ rtl/keyword_token_lexer.sv @@
// keyword_token_lexer: streaming lexer top level, byte classification and run tracking
// holds the run state and feeds result words into kwl_out_queue
// depends on kwl_pkg and kwl_out_queue
//
// The lexer takes one source byte, or an end-of-source word, per clock while
// not stalled and turns it into zero, one or two token words (a closed letter
// or digit run, then the byte's own token or the end token). Classification,
// keyword matching and run counting happen in the cycle the byte is taken; the
// resulting words are registered in a four-entry result queue that drains one
// word per cycle unless the result side stalls. An input word can be taken
// every cycle while the queue holds at most two words. Sustained input rate is
// one byte per cycle while tokens per byte average at most one (the single
// result port sets that limit) and the result side does not stall. Token
// positions count modulo 2^POS_BITS and are shown in their low 16 bits; an
// end-of-source word returns position and run state to their reset values.

module keyword_token_lexer #(
    parameter int unsigned POS_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kwl_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kwl_pkg::t_out_word o_out_word
);
    import kwl_pkg::*;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WORD = 2'd1;
    localparam logic [1:0] MODE_NUM  = 2'd2;

    logic [1:0]          r_mode, n_mode;
    logic [START_W-1:0]  r_tok_start, n_tok_start;
    logic [LEN_W-1:0]    r_tok_len, n_tok_len;
    logic                r_let_match, n_let_match;
    logic                r_print_match, n_print_match;
    logic [POS_BITS-1:0] r_position, n_position;

    logic                accept;
    logic                room2;
    logic [CH_W-1:0]     ch;
    logic                is_alpha, is_digit, is_space;
    logic                in_word, in_num;
    logic                close_v, own_v;
    logic [KIND_W-1:0]   close_kind, own_kind;
    logic [LEN_W-1:0]    len_inc;
    logic                let_next, print_next;
    t_out_word           close_word, own_word, word_a, word_b;
    logic [1:0]          push_cnt;
    logic [START_W-1:0]  pos_res;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = !room2;
    assign ch         = i_in_word.ch;
    assign pos_res    = START_W'(r_position);

    // byte classes
    always_comb begin
        is_alpha = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        is_digit = (ch inside {[8'h30:8'h39]});
        is_space = (ch inside {8'h20, [8'h09:8'h0D]});
    end

    assign in_word = (r_mode == MODE_WORD);
    assign in_num  = (r_mode == MODE_NUM);
    assign len_inc = (r_tok_len != LEN_MAX) ? r_tok_len + 1'b1 : r_tok_len;

    // keyword letter match at the current run offset
    always_comb begin
        case (r_tok_len)
            16'd1:   let_next = (ch == "e");
            16'd2:   let_next = (ch == "t");
            default: let_next = 1'b0;
        endcase
        case (r_tok_len)
            16'd1:   print_next = (ch == "r");
            16'd2:   print_next = (ch == "i");
            16'd3:   print_next = (ch == "n");
            16'd4:   print_next = (ch == "t");
            default: print_next = 1'b0;
        endcase
    end

    // kind of the pending run if it closes now
    always_comb begin
        if (in_word && r_let_match && r_tok_len == 16'd3) begin
            close_kind = KIND_LET;
        end else if (in_word && r_print_match && r_tok_len == 16'd5) begin
            close_kind = KIND_PRINT;
        end else if (in_word) begin
            close_kind = KIND_WORD;
        end else begin
            close_kind = KIND_NUMBER;
        end
    end

    // kind of a single byte token
    always_comb begin
        case (ch)
            CH_PLUS:   own_kind = KIND_PLUS;
            CH_MINUS:  own_kind = KIND_MINUS;
            CH_STAR:   own_kind = KIND_STAR;
            CH_SLASH:  own_kind = KIND_SLASH;
            CH_EQUAL:  own_kind = KIND_EQUAL;
            CH_SEMI:   own_kind = KIND_SEMI;
            CH_LPAREN: own_kind = KIND_LPAREN;
            CH_RPAREN: own_kind = KIND_RPAREN;
            default:   own_kind = KIND_UNKNOWN;
        endcase
    end

    // run tracking and result selection
    always_comb begin
        n_mode        = r_mode;
        n_tok_start   = r_tok_start;
        n_tok_len     = r_tok_len;
        n_let_match   = r_let_match;
        n_print_match = r_print_match;
        n_position    = r_position + 1'b1;
        close_v       = 1'b0;
        own_v         = 1'b0;
        own_word      = '0;

        if (i_in_word.end_of_source) begin
            close_v            = in_word || in_num;
            own_v              = 1'b1;
            own_word.kind      = KIND_END;
            own_word.start_res = pos_res;
            n_mode             = MODE_IDLE;
            n_tok_start        = '0;
            n_tok_len          = '0;
            n_let_match        = 1'b0;
            n_print_match      = 1'b0;
            n_position         = '0;
        end else if (is_alpha) begin
            if (in_word) begin
                n_let_match   = r_let_match && let_next;
                n_print_match = r_print_match && print_next;
                n_tok_len     = len_inc;
            end else begin
                close_v       = in_num;
                n_mode        = MODE_WORD;
                n_tok_start   = pos_res;
                n_tok_len     = 16'd1;
                n_let_match   = (ch == "l");
                n_print_match = (ch == "p");
            end
        end else if (is_digit) begin
            if (in_num) begin
                n_tok_len = len_inc;
            end else begin
                close_v       = in_word;
                n_mode        = MODE_NUM;
                n_tok_start   = pos_res;
                n_tok_len     = 16'd1;
                n_let_match   = 1'b0;
                n_print_match = 1'b0;
            end
        end else begin
            close_v = in_word || in_num;
            n_mode  = MODE_IDLE;
            if (!is_space) begin
                own_v              = 1'b1;
                own_word.kind      = own_kind;
                own_word.start_res = pos_res;
                own_word.length    = 16'd1;
                own_word.bad_char  = (own_kind == KIND_UNKNOWN) ? ch : '0;
            end
        end
        own_word.last = 1'b1;
    end

    // closed run word
    always_comb begin
        close_word           = '0;
        close_word.kind      = close_kind;
        close_word.start_res = r_tok_start;
        close_word.length    = r_tok_len;
        close_word.last      = !own_v;
    end

    // queue push: the closed run goes first
    always_comb begin
        word_a   = close_v ? close_word : own_word;
        word_b   = own_word;
        push_cnt = accept ? (2'(close_v) + 2'(own_v)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_tok_start   <= '0;
            r_tok_len     <= '0;
            r_let_match   <= 1'b0;
            r_print_match <= 1'b0;
            r_position    <= '0;
        end else if (accept) begin
            r_mode        <= n_mode;
            r_tok_start   <= n_tok_start;
            r_tok_len     <= n_tok_len;
            r_let_match   <= n_let_match;
            r_print_match <= n_print_match;
            r_position    <= n_position;
        end
    end

    kwl_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_word_a    (word_a),
        .i_word_b    (word_b),
        .o_room2     (room2),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

@@ rtl/kwl_out_queue.sv @@
// kwl_out_queue: four-entry queue, takes up to two words a cycle, gives one
// unless stalled; decouples the lexer step from the result channel stall
// depends on kwl_pkg

module kwl_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  kwl_pkg::t_out_word i_word_a,
    input  kwl_pkg::t_out_word i_word_b,
    output logic              o_room2,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output kwl_pkg::t_out_word o_out_word
);
    import kwl_pkg::*;

    t_out_word            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;
    logic [Q_PTR_W-1:0]   wr_ptr_b;
    logic                 pop;

    assign wr_ptr_b = r_wr_ptr + 1'b1;
    assign pop      = o_out_valid && !i_out_stall;

    // pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(pop);
        n_count  = r_count + Q_CNT_W'(i_push_cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_word_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_b] <= i_word_b;
        end
    end

    assign o_room2     = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_word  = r_mem[r_rd_ptr];

endmodule

@@ test/tb_top.sv @@
// tb_top: self-checking bench for keyword_token_lexer, one source byte or end mark per word
// predicts token words in the bench, compares every result word field by field
// depends on kwl_pkg and the keyword_token_lexer rtl
`timescale 1ns / 100ps

module tb_top;
    import kwl_pkg::*;

    localparam int CYC_LIMIT = 1000000;
    localparam int RAND_WORDS = 1350;
    localparam int HOLD_CYCLES = 400;
    localparam logic [23:0] KW_LET = "let";
    localparam logic [39:0] KW_PRINT = "print";

    typedef enum logic [1:0] {RUN_IDLE, RUN_LETTERS, RUN_DIGITS} t_run;

    typedef struct {
        t_in_word  word;
        int        n_typed;
        t_out_word typed0;
        t_out_word typed1;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // lexer state mirrored in the bench
    t_run        run_mode = RUN_IDLE;
    logic [15:0] run_start = '0;
    logic [15:0] run_len = '0;
    logic        let_ok = 1'b0;
    logic        print_ok = 1'b0;
    logic [15:0] pos_cnt = '0;

    t_out_word tok_pred_q[$];
    t_out_word tok_expect_q[$];
    t_dir_row  dir_tab[$];

    int  n_err = 0;
    int  n_res = 0;
    int  n_words = 0;
    int  cyc_cnt = 0;
    int  hold_cnt = 0;
    int  rcv_wait = 0;
    bit  snd_idle_on = 1'b1;
    bit  rcv_idle_on = 1'b1;
    bit  quiet = 1'b0;

    keyword_token_lexer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    // byte classes
    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(logic [7:0] c);
        case (c)
            CH_PLUS:   return KIND_PLUS;
            CH_MINUS:  return KIND_MINUS;
            CH_STAR:   return KIND_STAR;
            CH_SLASH:  return KIND_SLASH;
            CH_EQUAL:  return KIND_EQUAL;
            CH_SEMI:   return KIND_SEMI;
            CH_LPAREN: return KIND_LPAREN;
            CH_RPAREN: return KIND_RPAREN;
            default:   return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(bit is_print, int idx);
        return is_print ? KW_PRINT[8*(4-idx) +: 8] : KW_LET[8*(2-idx) +: 8];
    endfunction

    function automatic t_out_word mk_tok(logic [KIND_W-1:0] kind, logic [15:0] start,
                                         logic [15:0] len, logic [7:0] bad, logic lst);
        t_out_word t;
        t.kind = kind;
        t.start_res = start;
        t.length = len;
        t.bad_char = bad;
        t.last = lst;
        return t;
    endfunction

    // append to the predicted and expected word lists
    function automatic void add_pred(t_out_word t);
        tok_pred_q.insert(tok_pred_q.size(), t);
    endfunction

    function automatic void add_expect(t_out_word t);
        tok_expect_q.insert(tok_expect_q.size(), t);
    endfunction

    // emit the pending letter or digit run, if any
    function automatic void close_run();
        logic [KIND_W-1:0] kind;
        if (run_mode == RUN_LETTERS) begin
            if (let_ok && run_len == 16'd3)
                kind = KIND_LET;
            else if (print_ok && run_len == 16'd5)
                kind = KIND_PRINT;
            else
                kind = KIND_WORD;
            add_pred(mk_tok(kind, run_start, run_len, 8'h00, 1'b0));
        end else if (run_mode == RUN_DIGITS) begin
            add_pred(mk_tok(KIND_NUMBER, run_start, run_len, 8'h00, 1'b0));
        end
        run_mode = RUN_IDLE;
    endfunction

    // token words caused by one input word, left in tok_pred_q
    function automatic void lex_step(t_in_word w);
        logic [7:0]        c;
        logic [KIND_W-1:0] pk;
        c = w.ch;
        tok_pred_q.delete();
        if (w.end_of_source) begin
            close_run();
            add_pred(mk_tok(KIND_END, pos_cnt, 16'd0, 8'h00, 1'b0));
            run_mode = RUN_IDLE;
            run_start = '0;
            run_len = '0;
            let_ok = 1'b0;
            print_ok = 1'b0;
            pos_cnt = '0;
        end else begin
            if (is_letter(c)) begin
                if (run_mode == RUN_LETTERS) begin
                    let_ok = let_ok && run_len < 3 && c == kw_char(1'b0, int'(run_len));
                    print_ok = print_ok && run_len < 5 && c == kw_char(1'b1, int'(run_len));
                    if (run_len != LEN_MAX)
                        run_len++;
                end else begin
                    close_run();
                    run_mode = RUN_LETTERS;
                    run_start = pos_cnt;
                    run_len = 16'd1;
                    let_ok = (c == kw_char(1'b0, 0));
                    print_ok = (c == kw_char(1'b1, 0));
                end
            end else if (is_digit(c)) begin
                if (run_mode == RUN_DIGITS) begin
                    if (run_len != LEN_MAX)
                        run_len++;
                end else begin
                    close_run();
                    run_mode = RUN_DIGITS;
                    run_start = pos_cnt;
                    run_len = 16'd1;
                    let_ok = 1'b0;
                    print_ok = 1'b0;
                end
            end else begin
                close_run();
                if (!is_blank(c)) begin
                    pk = punct_kind(c);
                    add_pred(mk_tok(pk, pos_cnt, 16'd1,
                                    pk == KIND_UNKNOWN ? c : 8'h00, 1'b0));
                end
            end
            pos_cnt++;
        end
        if (tok_pred_q.size() > 0)
            tok_pred_q[tok_pred_q.size()-1].last = 1'b1;
    endfunction

    // offer one word, wait for the handshake, then predict
    task automatic send_word(t_in_word w);
        int gap;
        gap = (snd_idle_on && !quiet) ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        lex_step(w);
    endtask

    task automatic send_ch(logic [7:0] c);
        t_in_word w;
        w.ch = c;
        w.end_of_source = 1'b0;
        send_word(w);
        foreach (tok_pred_q[k]) add_expect(tok_pred_q[k]);
        n_words++;
    endtask

    task automatic send_eos(logic [7:0] junk);
        t_in_word w;
        w.ch = junk;
        w.end_of_source = 1'b1;
        send_word(w);
        foreach (tok_pred_q[k]) add_expect(tok_pred_q[k]);
        n_words++;
    endtask

    task automatic add_row(logic [7:0] c, logic eos, int n, t_out_word t0, t_out_word t1);
        t_dir_row r;
        r.word.ch = c;
        r.word.end_of_source = eos;
        r.n_typed = n;
        r.typed0 = t0;
        r.typed1 = t1;
        dir_tab.insert(dir_tab.size(), r);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return c + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'(9 + k);
    endfunction

    function automatic logic [7:0] odd_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_letter(c) || is_digit(c) || is_blank(c) || punct_kind(c) != KIND_UNKNOWN);
        return c;
    endfunction

    function automatic logic [7:0] punct_byte(int k);
        case (k)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_EQUAL;
            5:       return CH_SEMI;
            6:       return CH_LPAREN;
            default: return CH_RPAREN;
        endcase
    endfunction

    task automatic check_word(t_out_word got, t_out_word want);
        if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            n_err++;
        end
        if (got.start_res !== want.start_res) begin
            $error("start_res: expected %0d, got %0d", want.start_res, got.start_res);
            n_err++;
        end
        if (got.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            n_err++;
        end
        if (got.bad_char !== want.bad_char) begin
            $error("bad_char: expected %0h, got %0h", want.bad_char, got.bad_char);
            n_err++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            n_err++;
        end
    endtask

    // result side: check, random stall per word, long hold-offs to fill the block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (tok_expect_q.size() == 0) begin
                    $error("unexpected result word: kind %0d start %0d",
                           o_out_word.kind, o_out_word.start_res);
                    n_err++;
                end else begin
                    check_word(o_out_word, tok_expect_q.pop_front());
                end
                n_res++;
                if (n_res == 300 || n_res == 900)
                    hold_cnt = HOLD_CYCLES;
                if (n_res % 64 == 0)
                    rcv_idle_on = ($urandom_range(0, 3) != 0);
                rcv_wait = (rcv_idle_on && !quiet) ? $urandom_range(0, 14) : 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall <= 1'b1;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYC_LIMIT) begin
            $display("[keyword_token_lexer] ERROR");
            $finish;
        end
    end

    initial begin
        int          sel;
        int          len;
        int          klen;
        bit          is_print;
        t_out_word   none;
        logic [7:0]  c;

        none = '0;

        // directed rows: positions restart at zero after each end mark
        add_row(8'h00, 1'b1, 1, mk_tok(KIND_END, 16'd0, 16'd0, 8'h00, 1'b1), none);
        add_row(CH_PLUS, 1'b0, 1, mk_tok(KIND_PLUS, 16'd0, 16'd1, 8'h00, 1'b1), none);
        add_row("l", 1'b0, 0, none, none);
        add_row("e", 1'b0, 0, none, none);
        add_row("t", 1'b0, 0, none, none);
        add_row(8'h09, 1'b0, 1, mk_tok(KIND_LET, 16'd1, 16'd3, 8'h00, 1'b1), none);
        add_row("p", 1'b0, 0, none, none);
        add_row("r", 1'b0, 0, none, none);
        add_row("i", 1'b0, 0, none, none);
        add_row("n", 1'b0, 0, none, none);
        add_row("t", 1'b0, 0, none, none);
        add_row(CH_LPAREN, 1'b0, 2, mk_tok(KIND_PRINT, 16'd5, 16'd5, 8'h00, 1'b0),
                mk_tok(KIND_LPAREN, 16'd10, 16'd1, 8'h00, 1'b1));
        add_row("0", 1'b0, 0, none, none);
        add_row("9", 1'b0, 0, none, none);
        add_row(CH_RPAREN, 1'b0, 0, none, none);
        add_row(8'h00, 1'b0, 1, mk_tok(KIND_UNKNOWN, 16'd14, 16'd1, 8'h00, 1'b1), none);
        add_row(8'hFF, 1'b0, 1, mk_tok(KIND_UNKNOWN, 16'd15, 16'd1, 8'hFF, 1'b1), none);
        add_row("Z", 1'b0, 0, none, none);
        add_row("a", 1'b0, 0, none, none);
        add_row(CH_STAR, 1'b0, 0, none, none);
        add_row(CH_SLASH, 1'b0, 0, none, none);
        add_row(CH_EQUAL, 1'b0, 0, none, none);
        add_row(CH_SEMI, 1'b0, 0, none, none);
        add_row(CH_MINUS, 1'b0, 0, none, none);
        add_row(8'hFF, 1'b1, 1, mk_tok(KIND_END, 16'd23, 16'd0, 8'h00, 1'b1), none);

        // reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: typed rows override the prediction, state still advances
        foreach (dir_tab[r]) begin
            send_word(dir_tab[r].word);
            if (dir_tab[r].n_typed == 0) begin
                foreach (tok_pred_q[k]) add_expect(tok_pred_q[k]);
            end else begin
                add_expect(dir_tab[r].typed0);
                if (dir_tab[r].n_typed == 2)
                    add_expect(dir_tab[r].typed1);
            end
        end

        // one huge letter run: length saturates and position wraps
        quiet = 1'b1;
        send_ch("l");
        send_ch("e");
        send_ch("t");
        repeat (65540) send_ch("b");
        send_ch("5");
        send_ch("7");
        send_ch(CH_SEMI);
        send_eos(8'h00);
        quiet = 1'b0;

        // random part: mostly well-formed token streams, some noise
        n_words = 0;
        while (n_words < RAND_WORDS) begin
            if (n_words % 50 == 0)
                snd_idle_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 99);
            if (sel < 22) begin
                // exact keyword
                is_print = (sel >= 12);
                klen = is_print ? 5 : 3;
                for (int i = 0; i < klen; i++) send_ch(kw_char(is_print, i));
            end else if (sel < 35) begin
                // near miss: prefix, extension or letters changed
                is_print = $urandom_range(0, 1);
                klen = is_print ? 5 : 3;
                len = $urandom_range(1, klen + 2);
                for (int i = 0; i < len; i++) begin
                    if (i < klen && $urandom_range(0, 4) != 0)
                        c = kw_char(is_print, i);
                    else
                        c = rand_letter();
                    send_ch(c);
                end
            end else if (sel < 50) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
                repeat (len) send_ch(rand_letter());
            end else if (sel < 63) begin
                len = $urandom_range(1, 6);
                repeat (len) send_ch(8'("0") + 8'($urandom_range(0, 9)));
            end else if (sel < 80) begin
                send_ch(punct_byte($urandom_range(0, 7)));
            end else if (sel < 86) begin
                send_ch(odd_byte());
            end else if (sel < 90) begin
                send_eos(8'($urandom_range(0, 255)));
            end else begin
                send_ch(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 0)
                send_ch(rand_blank());
        end
        send_eos(8'($urandom_range(0, 255)));
        i_in_valid <= 1'b0;

        // drain, then wait on with the input idle to catch stray words
        while (tok_expect_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (n_err == 0)
            $display("[keyword_token_lexer] OK");
        else
            $display("[keyword_token_lexer] ERROR");
        $finish;
    end

endmodule
